// File: design/edf_pkg.sv
// Shared types and constants for the escaped frame deframer.
package edf_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_TAIL    = 2'd1;
    localparam logic [1:0] CFG_ESCAPE  = 2'd2;
    localparam logic [1:0] CFG_ADDRESS = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SUM   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_RESTARTED = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       is_header;
        logic       is_tail;
        logic       is_escape;
    } edf_token_t;

endpackage

// File: design/edf_front.sv
// Front end: accepts raw bytes and tags them against the control byte values.
module edf_front
    import edf_pkg::*;
(
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic [7:0] header_byte,
    input  logic [7:0] tail_byte,
    input  logic [7:0] escape_byte,
    input  logic       queue_full,
    output logic       push,
    output edf_token_t push_token
);

    assign rx_ready = !queue_full;
    assign push     = rx_valid && !queue_full;

    always_comb
    begin
        push_token.data      = rx_byte;
        push_token.is_header = (rx_byte == header_byte);
        push_token.is_tail   = (rx_byte == tail_byte);
        push_token.is_escape = (rx_byte == escape_byte);
    end

endmodule

// File: design/edf_queue.sv
// Short queue of tagged bytes between the front end and the frame engine.
module edf_queue
    import edf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  edf_token_t        push_token,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output edf_token_t        head,
    output logic [QPTR_W:0]   count
);

    edf_token_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/edf_back.sv
// Frame engine: unescapes the body, tracks sum and count, and registers results.
module edf_back
    import edf_pkg::*;
#(
    parameter int FRAME_BYTES  = 64,
    parameter int HEADER_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  edf_token_t tok,
    input  logic [7:0] device_address,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [2:0] status,
    output logic       for_this_device,
    output logic [7:0] function_code,
    output logic [6:0] payload_length
);

    localparam int CW = $clog2(FRAME_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HUNT1,
        PH_BODY,
        PH_ESC,
        PH_LAST_T,
        PH_LAST_H
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      sum_reg, sum_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      held0_reg, held0_next;
    logic [7:0]      held1_reg, held1_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic [7:0]      addr_reg, addr_next;
    logic [7:0]      func_reg, func_next;

    logic            res_valid_reg, res_valid_next;
    logic            kind_reg, kind_next;
    logic [7:0]      payload_reg, payload_next;
    logic [2:0]      status_reg, status_next;
    logic            match_reg, match_next;
    logic [7:0]      fcode_reg, fcode_next;
    logic [6:0]      length_reg, length_next;

    logic            take;
    logic            do_dec;
    logic            do_clear;
    phase_t          dec_phase;
    logic            end_match;
    logic [7:0]      end_func;
    logic [31:0]     len_full;

    assign tok_ready = !res_valid_reg || res_ready;
    assign take      = tok_valid && tok_ready;

    assign end_match = (count_reg != '0) && (addr_reg == device_address);
    assign end_func  = (int'(count_reg) >= 2) ? func_reg : 8'd0;
    assign len_full  = 32'(count_reg) - 32'(HEADER_BYTES + 2);

    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        held_cnt_next  = held_cnt_reg;
        addr_next      = addr_reg;
        func_next      = func_reg;
        res_valid_next = res_valid_reg && !res_ready;
        kind_next      = kind_reg;
        payload_next   = payload_reg;
        status_next    = status_reg;
        match_next     = match_reg;
        fcode_next     = fcode_reg;
        length_next    = length_reg;
        do_dec         = 1'b0;
        do_clear       = 1'b0;
        dec_phase      = PH_BODY;

        if (take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (tok.is_header)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HUNT1:
                begin
                    if (tok.is_header)
                    begin
                        do_clear   = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_ESC:
                begin
                    do_dec    = 1'b1;
                    dec_phase = PH_BODY;
                end
                default:
                begin
                    if (phase_reg == PH_LAST_T && tok.is_tail)
                    begin
                        res_valid_next = 1'b1;
                        kind_next      = KIND_END;
                        payload_next   = 8'd0;
                        match_next     = end_match;
                        fcode_next     = end_func;
                        length_next    = 7'd0;
                        if (int'(count_reg) < HEADER_BYTES + 2)
                        begin
                            status_next = ST_SHORT;
                        end
                        else if (sum_reg == held0_reg)
                        begin
                            status_next = ST_OK;
                            length_next = len_full[6:0];
                        end
                        else
                        begin
                            status_next = ST_BAD_SUM;
                        end
                        do_clear   = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else if (phase_reg == PH_LAST_H && tok.is_header)
                    begin
                        res_valid_next = 1'b1;
                        kind_next      = KIND_END;
                        payload_next   = 8'd0;
                        status_next    = ST_RESTARTED;
                        match_next     = end_match;
                        fcode_next     = end_func;
                        length_next    = 7'd0;
                        do_clear       = 1'b1;
                        phase_next     = PH_BODY;
                    end
                    else if (count_reg == '0 && tok.is_header)
                    begin
                        phase_next = phase_reg;
                    end
                    else if (tok.is_escape)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (tok.is_tail)
                    begin
                        do_dec    = 1'b1;
                        dec_phase = PH_LAST_T;
                    end
                    else if (tok.is_header)
                    begin
                        do_dec    = 1'b1;
                        dec_phase = PH_LAST_H;
                    end
                    else
                    begin
                        do_dec    = 1'b1;
                        dec_phase = PH_BODY;
                    end
                end
            endcase

            if (do_dec)
            begin
                if (int'(count_reg) >= FRAME_BYTES)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_END;
                    payload_next   = 8'd0;
                    status_next    = ST_OVERFLOW;
                    match_next     = end_match;
                    fcode_next     = end_func;
                    length_next    = 7'd0;
                    do_clear       = 1'b1;
                    phase_next     = PH_HUNT;
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        addr_next = tok.data;
                    end
                    else if (count_reg == CW'(1))
                    begin
                        func_next = tok.data;
                    end
                    if (held_cnt_reg == 2'd2)
                    begin
                        sum_next = sum_reg + held0_reg;
                        if (int'(count_reg) >= HEADER_BYTES + 2)
                        begin
                            res_valid_next = 1'b1;
                            kind_next      = KIND_PAYLOAD;
                            payload_next   = held0_reg;
                            status_next    = ST_OK;
                            match_next     = 1'b0;
                            fcode_next     = 8'd0;
                            length_next    = 7'd0;
                        end
                        held0_next = held1_reg;
                        held1_next = tok.data;
                    end
                    else
                    begin
                        if (held_cnt_reg == 2'd0)
                        begin
                            held0_next = tok.data;
                        end
                        else
                        begin
                            held1_next = tok.data;
                        end
                        held_cnt_next = held_cnt_reg + 2'd1;
                    end
                    count_next = count_reg + 1'b1;
                    phase_next = dec_phase;
                end
            end

            if (do_clear)
            begin
                sum_next      = 8'd0;
                count_next    = '0;
                held0_next    = 8'd0;
                held1_next    = 8'd0;
                held_cnt_next = 2'd0;
                addr_next     = 8'd0;
                func_next     = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            sum_reg       <= 8'd0;
            count_reg     <= '0;
            held0_reg     <= 8'd0;
            held1_reg     <= 8'd0;
            held_cnt_reg  <= 2'd0;
            addr_reg      <= 8'd0;
            func_reg      <= 8'd0;
            res_valid_reg <= 1'b0;
            kind_reg      <= KIND_PAYLOAD;
            payload_reg   <= 8'd0;
            status_reg    <= ST_OK;
            match_reg     <= 1'b0;
            fcode_reg     <= 8'd0;
            length_reg    <= 7'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            held_cnt_reg  <= held_cnt_next;
            addr_reg      <= addr_next;
            func_reg      <= func_next;
            res_valid_reg <= res_valid_next;
            kind_reg      <= kind_next;
            payload_reg   <= payload_next;
            status_reg    <= status_next;
            match_reg     <= match_next;
            fcode_reg     <= fcode_next;
            length_reg    <= length_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign kind            = kind_reg;
    assign payload_byte    = payload_reg;
    assign status          = status_reg;
    assign for_this_device = match_reg;
    assign function_code   = fcode_reg;
    assign payload_length  = length_reg;

endmodule

// File: design/escaped_frame_deframer.sv
// Top level of the escaped frame deframer: configuration, front end, queue and engine.
// The deframer takes one received byte per clock cycle while rx_ready is high and gives
// at most one result per byte, each result being registered in the engine before it
// is shown on the outputs. The front end tags each byte against the header, tail and
// escape values and places it in a four-entry queue; the frame engine takes one byte
// from the queue per cycle whenever its output register is empty or being read, so the
// sustained rate is one byte per cycle and a stalled output fills the queue before
// rx_ready drops. Configuration registers are written through cfg_write and must only
// change while no bytes are queued and no result is pending.
module escaped_frame_deframer
    import edf_pkg::*;
#(
    parameter int FRAME_BYTES  = 64,
    parameter int HEADER_BYTES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [2:0] status,
    output logic       for_this_device,
    output logic [7:0] function_code,
    output logic [6:0] payload_length
);

    logic [7:0]      header_reg;
    logic [7:0]      tail_reg;
    logic [7:0]      escape_reg;
    logic [7:0]      address_reg;

    logic            queue_full;
    logic            queue_not_empty;
    logic            push;
    logic            pop;
    logic            tok_ready;
    edf_token_t      push_token;
    edf_token_t      head;
    logic [QPTR_W:0] queue_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= 8'hAA;
            tail_reg    <= 8'h55;
            escape_reg  <= 8'hA5;
            address_reg <= 8'h01;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_TAIL:    tail_reg    <= cfg_data;
                CFG_ESCAPE:  escape_reg  <= cfg_data;
                CFG_ADDRESS: address_reg <= cfg_data;
                default:     header_reg  <= header_reg;
            endcase
        end
    end

    edf_front u_front (
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .escape_byte (escape_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_token  (push_token)
    );

    assign pop = queue_not_empty && tok_ready;

    edf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head),
        .count      (queue_count)
    );

    edf_back #(
        .FRAME_BYTES  (FRAME_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .tok_valid       (queue_not_empty),
        .tok_ready       (tok_ready),
        .tok             (head),
        .device_address  (address_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .status          (status),
        .for_this_device (for_this_device),
        .function_code   (function_code),
        .payload_length  (payload_length)
    );

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> queue_count == (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("Input stalled while the queue has room.");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (queue_not_empty && (!res_valid || res_ready) && !push)
        |=> queue_count == $past(queue_count) - 1'b1)
        else $error("Queue did not drain while the engine was free.");

    a_payload_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind == KIND_PAYLOAD) |->
        (status == ST_OK && !for_this_device && function_code == 8'd0 &&
         payload_length == 7'd0))
        else $error("Payload item carries end-of-frame fields.");

    a_length_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind == KIND_END && status != ST_OK) |->
        (payload_length == 7'd0 && payload_byte == 8'd0))
        else $error("Failed frame reports a length.");

endmodule

// File: test/tb_escaped_frame_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for escaped_frame_deframer with a byte-level frame predictor.
module tb_escaped_frame_deframer;
    import edf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int FRAME_BYTES  = 64;
    localparam int HEADER_BYTES = 4;
    localparam int IDLE_CYCLES  = 12;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_BYTES  = 115;
    localparam int LIMIT_NS     = 2_000_000;

    typedef enum logic [2:0] {
        LS_HUNT,
        LS_ONE_HDR,
        LS_BODY,
        LS_ESCAPED,
        LS_AFTER_TAIL,
        LS_AFTER_HDR
    } link_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] status;
        logic       mine;
        logic [7:0] func;
        logic [6:0] len;
    } frame_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = CFG_HEADER;
    logic [7:0] cfg_data = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       for_this_device;
    logic [7:0] function_code;
    logic [6:0] payload_length;

    // Register copies used by the predictor and the frame generator.
    logic [7:0] hdr_val = 8'hAA;
    logic [7:0] tail_val = 8'h55;
    logic [7:0] esc_val = 8'hA5;
    logic [7:0] addr_val = 8'h01;

    link_state_t link_state = LS_HUNT;
    logic [7:0]  frame_sum = '0;
    int unsigned frame_count = 0;
    logic [7:0]  held0 = '0;
    logic [7:0]  held1 = '0;
    int unsigned held_n = 0;
    logic [7:0]  frame_addr = '0;
    logic [7:0]  frame_func = '0;

    logic [7:0]    tx_bytes[$];
    frame_result_t results_due[$];
    frame_result_t got_res;
    frame_result_t want_res;

    int unsigned bytes_made = 0;
    int unsigned bytes_taken = 0;
    int unsigned payload_seen = 0;
    int unsigned ends_seen = 0;
    int unsigned ends_by_status [5];
    int unsigned config_sets = 1;
    int unsigned mismatches = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    logic        hold_req = 1'b0;
    logic        hold_off = 1'b0;

    escaped_frame_deframer #(
        .FRAME_BYTES  (FRAME_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .status          (status),
        .for_this_device (for_this_device),
        .function_code   (function_code),
        .payload_length  (payload_length)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void show_result(string tag, frame_result_t r);
        $display("%0t: %s kind=%0d byte=%02h status=%0d mine=%0d func=%02h len=%0d",
                 $time, tag, r.kind, r.data, r.status, r.mine, r.func, r.len);
    endfunction

    function automatic void reset_frame();
        frame_sum   = '0;
        frame_count = 0;
        held0       = '0;
        held1       = '0;
        held_n      = 0;
        frame_addr  = '0;
        frame_func  = '0;
    endfunction

    function automatic void finish_frame(logic [2:0] st, logic [6:0] len);
        frame_result_t r;
        r.kind   = KIND_END;
        r.data   = '0;
        r.status = st;
        r.mine   = (frame_count >= 1 && frame_addr == addr_val);
        r.func   = (frame_count >= 2) ? frame_func : 8'h00;
        r.len    = len;
        results_due.push_back(r);
    endfunction

    function automatic void accept_decoded(logic [7:0] v, link_state_t nxt);
        frame_result_t r;
        if (frame_count >= FRAME_BYTES)
        begin
            finish_frame(ST_OVERFLOW, '0);
            reset_frame();
            link_state = LS_HUNT;
            return;
        end
        if (frame_count == 0)
            frame_addr = v;
        else if (frame_count == 1)
            frame_func = v;
        if (held_n >= 2)
        begin
            frame_sum = frame_sum + held0;
            if (frame_count - 2 >= HEADER_BYTES)
            begin
                r        = '0;
                r.kind   = KIND_PAYLOAD;
                r.data   = held0;
                r.status = ST_OK;
                results_due.push_back(r);
            end
            held0 = held1;
            held1 = v;
        end
        else
        begin
            if (held_n == 0)
                held0 = v;
            else
                held1 = v;
            held_n++;
        end
        frame_count++;
        link_state = nxt;
    endfunction

    function automatic void step_link(logic [7:0] b);
        int unsigned content;
        case (link_state)
            LS_HUNT:
            begin
                if (b == hdr_val)
                    link_state = LS_ONE_HDR;
            end
            LS_ONE_HDR:
            begin
                if (b == hdr_val)
                begin
                    reset_frame();
                    link_state = LS_BODY;
                end
                else
                begin
                    link_state = LS_HUNT;
                end
            end
            LS_ESCAPED: accept_decoded(b, LS_BODY);
            default:
            begin
                if (link_state == LS_AFTER_TAIL && b == tail_val)
                begin
                    content = frame_count - 1;
                    if (content < HEADER_BYTES + 1)
                        finish_frame(ST_SHORT, '0);
                    else if (frame_sum == held0)
                        finish_frame(ST_OK, 7'(content - 1 - HEADER_BYTES));
                    else
                        finish_frame(ST_BAD_SUM, '0);
                    reset_frame();
                    link_state = LS_HUNT;
                end
                else if (link_state == LS_AFTER_HDR && b == hdr_val)
                begin
                    finish_frame(ST_RESTARTED, '0);
                    reset_frame();
                    link_state = LS_BODY;
                end
                else if (frame_count == 0 && b == hdr_val)
                begin
                    link_state = LS_BODY;
                end
                else if (b == esc_val)
                begin
                    link_state = LS_ESCAPED;
                end
                else if (b == tail_val)
                begin
                    accept_decoded(b, LS_AFTER_TAIL);
                end
                else if (b == hdr_val)
                begin
                    accept_decoded(b, LS_AFTER_HDR);
                end
                else
                begin
                    accept_decoded(b, LS_BODY);
                end
            end
        endcase
    endfunction

    function automatic void push_raw(logic [7:0] v);
        tx_bytes.push_back(v);
        bytes_made++;
    endfunction

    // A control value in the content is escaped, except now and then on purpose.
    function automatic void push_coded(logic [7:0] v);
        if ((v == hdr_val || v == tail_val || v == esc_val) && $urandom_range(0, 49) != 0)
            push_raw(esc_val);
        push_raw(v);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return hdr_val;
            1: return tail_val;
            2: return esc_val;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_frame();
        int unsigned shape;
        int unsigned n_content;
        int unsigned n_cut;
        int unsigned i;
        logic [7:0]  sum;
        logic [7:0]  v;
        shape = $urandom_range(0, 99);
        push_raw(hdr_val);
        push_raw(hdr_val);
        if (shape < 10)
            push_raw(hdr_val);
        if (shape >= 94)
            n_content = HEADER_BYTES + $urandom_range(50, 62);
        else if (shape >= 86)
            n_content = $urandom_range(0, HEADER_BYTES);
        else
            n_content = HEADER_BYTES + $urandom_range(0, 12);
        n_cut = (shape >= 70 && shape < 78) ? $urandom_range(1, 6) : 0;
        sum = '0;
        for (i = 0; i < n_content; i++)
        begin
            if (n_cut != 0 && i == n_cut)
            begin
                push_raw(hdr_val);
                push_raw(hdr_val);
                return;
            end
            v = (i == 0 && $urandom_range(0, 2) != 0) ? addr_val : pick_byte();
            push_coded(v);
            sum = sum + v;
        end
        if (shape >= 78 && shape < 82)
            return;
        if (shape >= 60 && shape < 70)
            sum = sum + 8'($urandom_range(1, 255));
        if (shape < 86 || shape >= 94)
            push_coded(sum);
        push_raw(tail_val);
        push_raw(tail_val);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) push_raw(8'($urandom));
    endfunction

    task automatic fill_random_phase();
        int unsigned start;
        start = bytes_made;
        while (bytes_made - start < PHASE_BYTES)
            add_frame();
    endtask

    task automatic drain();
        while (tx_bytes.size() != 0 || rx_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_HEADER:  hdr_val = val;
            CFG_TAIL:    tail_val = val;
            CFG_ESCAPE:  esc_val = val;
            CFG_ADDRESS: addr_val = val;
        endcase
    endtask

    task automatic load_config(logic [7:0] h, logic [7:0] t, logic [7:0] e, logic [7:0] a);
        write_reg(CFG_HEADER, h);
        write_reg(CFG_TAIL, t);
        write_reg(CFG_ESCAPE, e);
        write_reg(CFG_ADDRESS, a);
        @(posedge clk);
        cfg_write <= 1'b0;
        config_sets++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                step_link(rx_byte);
                void'(tx_bytes.pop_front());
                bytes_taken++;
            end
            if (rx_valid && !rx_ready)
            begin
                rx_valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                rx_valid <= 1'b0;
            end
            else if (tx_bytes.size() > 0)
            begin
                rx_valid <= 1'b1;
                rx_byte  <= tx_bytes[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                rx_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 160);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0: res_ready <= !hold_off;
                1: res_ready <= !hold_off && ($urandom_range(0, 1) == 0);
                default: res_ready <= !hold_off && ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            got_res.kind   = kind;
            got_res.data   = payload_byte;
            got_res.status = status;
            got_res.mine   = for_this_device;
            got_res.func   = function_code;
            got_res.len    = payload_length;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    show_result("result with none expected:", got_res);
            end
            else
            begin
                want_res = results_due.pop_front();
                if (want_res.kind == KIND_END)
                begin
                    ends_seen++;
                    ends_by_status[want_res.status]++;
                end
                else
                begin
                    payload_seen++;
                end
                if (got_res.kind !== want_res.kind || got_res.data !== want_res.data ||
                    got_res.status !== want_res.status || got_res.mine !== want_res.mine ||
                    got_res.func !== want_res.func || got_res.len !== want_res.len)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        show_result("expected", want_res);
                        show_result("actual  ", got_res);
                    end
                end
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short frame, escaped frame with an extra header byte, restart, and bad checksum.
        tx_bytes = {8'hAA, 8'hAA, 8'h55, 8'h55,
                    8'hAA, 8'hAA, 8'hAA, 8'h01, 8'hFF, 8'hA5, 8'hAA, 8'hA5, 8'h55,
                    8'hA5, 8'hA5, 8'h00, 8'hA4, 8'h55, 8'h55,
                    8'hAA, 8'hAA, 8'h07, 8'hAA, 8'hAA, 8'h55, 8'h55,
                    8'hAA, 8'hAA, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h55, 8'h55};
        bytes_made = tx_bytes.size();
        drain();

        fill_random_phase();
        hold_req = 1'b1;
        drain();

        load_config(8'h00, 8'hFF, 8'h80, 8'hFF);
        fill_random_phase();
        drain();

        load_config(8'hFF, 8'h00, 8'h7F, 8'h00);
        fill_random_phase();
        drain();

        load_config(8'h3C, 8'h3C, 8'h10, 8'($urandom));
        fill_random_phase();
        drain();

        load_config(8'h7E, 8'h81, 8'h7E, 8'h42);
        fill_random_phase();
        drain();

        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        fill_random_phase();
        drain();

        $display("Covered %0d link bytes, %0d register sets, %0d payload bytes, %0d frame ends.",
                 bytes_taken, config_sets, payload_seen, ends_seen);
        $display("Frame ends: ok %0d, bad sum %0d, overflow %0d, too short %0d, restarted %0d.",
                 ends_by_status[ST_OK], ends_by_status[ST_BAD_SUM],
                 ends_by_status[ST_OVERFLOW], ends_by_status[ST_SHORT],
                 ends_by_status[ST_RESTARTED]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
